/* hdl/assert_macros.svh */
// Assertion macros for the clock servo block.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked assertion, masked while reset is asserted.
`define PICS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked assertion, live through reset as well.
`define PICS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/pics_pkg.sv */
// Shared types and constants of the PI clock servo.
// No dependencies.
package pics_pkg;
    localparam int PROD_W = 111;
    localparam int MULB_W = 47;
    localparam int QUOT_W = 61;
    localparam logic [MULB_W-1:0] NS_Q16 = 47'd65536000000000;
    localparam logic [QUOT_W-1:0] TERM_CAP = 61'h1000_0000_0000_0000;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_MAX_PPB       = 3'd2,
        REG_MAX_OFFSET    = 3'd3,
        REG_MAX_FIRST_OFF = 3'd4,
        REG_MIN_EST_INT   = 3'd5,
        REG_INIT_DRIFT    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_UNLOCKED = 2'd0,
        ST_JUMP     = 2'd1,
        ST_LOCKED   = 2'd2
    } t_status;

    typedef struct packed {
        logic       start;
        logic [5:0] nbits;
    } t_mul_ctl;
endpackage

/* hdl/pics_in_if.sv */
// Input channel of the clock servo: offset sample and local timestamp.
// No dependencies.
interface pics_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] offset_ns;
    logic [63:0]        local_time_ns;
    modport source(output valid, offset_ns, local_time_ns, input ready);
    modport sink(input valid, offset_ns, local_time_ns, output ready);
endinterface

/* hdl/pics_out_if.sv */
// Output channel of the clock servo: correction and servo status.
// No dependencies.
interface pics_out_if;
    logic               valid;
    logic               ready;
    logic signed [46:0] correction_ppb_q16;
    logic [1:0]         servo_status;
    modport source(output valid, correction_ppb_q16, servo_status, input ready);
    modport sink(input valid, correction_ppb_q16, servo_status, output ready);
endinterface

/* hdl/pics_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on pics_pkg.
module pics_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pics_pkg::t_mul_ctl       i_ctl,
    input  logic [63:0]              i_a,
    input  logic [pics_pkg::MULB_W-1:0] i_b,
    output logic                     o_done,
    output logic [pics_pkg::PROD_W-1:0] o_prod
);
    import pics_pkg::*;

    logic [PROD_W-1:0] r_acc;
    logic [MULB_W-1:0] r_b;
    logic [63:0]       r_a;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.nbits;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= {r_acc[PROD_W-2:0], 1'b0}
                         + (r_b[MULB_W-1] ? {{(PROD_W-64){1'b0}}, r_a} : '0);
                r_b   <= {r_b[MULB_W-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* hdl/pics_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle; quotient
// saturates at TERM_CAP. Depends on pics_pkg.
module pics_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pics_pkg::PROD_W-1:0] i_dvd,
    input  logic [63:0]                 i_dvs,
    output logic                        o_done,
    output logic [pics_pkg::QUOT_W-1:0] o_quot
);
    import pics_pkg::*;

    logic [PROD_W-1:0] r_dvd;
    logic [63:0]       r_dvs;
    logic [63:0]       r_rem;
    logic [QUOT_W:0]   r_q;
    logic              r_ovf;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [64:0]       w_rem2;
    logic              w_ge;

    assign w_rem2 = {r_rem, r_dvd[PROD_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(PROD_W);
                r_dvd  <= i_dvd;
                r_dvs  <= i_dvs;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= w_ge ? 64'(w_rem2 - {1'b0, r_dvs}) : w_rem2[63:0];
                r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
                // remember any quotient bit that falls off the top
                r_q   <= {r_q[QUOT_W-1:0], w_ge};
                r_ovf <= r_ovf | r_q[QUOT_W];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || r_q > {1'b0, TERM_CAP}) ? TERM_CAP : r_q[QUOT_W-1:0];
endmodule

/* hdl/pi_clock_servo.sv */
// PI clock servo top level: sequencer, state and configuration registers.
// Depends on pics_pkg, pics_in_if, pics_out_if, pics_mul, pics_div,
// assert_macros.svh.
//
// Usage: each word on i_in carries a measured offset and its local timestamp;
// exactly one word leaves on o_out per input word, with a Q31.16 correction
// in ppb and a status (unlocked, jump, locked). Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// A stored first sample, an unlock, a short gap or a rejected timestamp is
// answered straight from the decode state; a drift estimate runs 47 multiply
// steps plus 111 divide steps of the bit-serial units, and locked operation
// runs two 32-step gain multiplies. One word is worked on at a time, and
// i_in.ready rises again as the result is parked in the output register.
// Reset restores the default gains and limits, zero drift and the wait for a
// first sample. When the receiver stalls, the result holds in the output
// register; a following word can be taken, but its result waits for space.
module pi_clock_servo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pics_in_if.sink     i_in,
    pics_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);
    import pics_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_EMUL, S_EDIV, S_IMUL, S_PMUL, S_PSUM, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_EST    = 2'd1,
        PH_LOCKED = 2'd2
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [31:0] r_prop_gain, r_integ_gain;
    logic [29:0] r_max_ppb;
    logic [39:0] r_max_off, r_max_first_off, r_min_int;
    logic signed [47:0] r_drift;
    logic        r_pending;

    logic signed [63:0] r_off, r_first_off;
    logic [63:0] r_t, r_first_t, r_dt;
    logic        r_neg;
    logic signed [61:0] r_iterm;
    logic signed [62:0] r_sum;
    logic [46:0] r_res_ppb;
    t_status     r_res_st;
    logic        r_ov;
    logic [46:0] r_corr;
    t_status     r_st;

    t_mul_ctl    r_mul_ctl;
    logic [63:0] r_ma;
    logic [MULB_W-1:0] r_mb;
    logic        r_div_start;
    logic        w_mul_done, w_div_done;
    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] w_quot;

    logic [63:0] w_amag, w_dt, w_dmag;
    logic        w_big_off, w_big_first, w_dneg;
    logic signed [62:0] w_lim, w_esum, w_eclamp, w_dsum;
    logic signed [61:0] w_term;

    pics_mul u_mul (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_ctl(r_mul_ctl),
        .i_a    (r_ma), .i_b(r_mb), .o_done(w_mul_done), .o_prod(w_prod)
    );

    pics_div u_div (
        .i_clk  (i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dvd  (w_prod), .i_dvs(r_dt), .o_done(w_div_done), .o_quot(w_quot)
    );

    // gain product in Q16: drop 8 fraction bits, cap, then sign by offset
    function automatic logic signed [61:0] f_term(input logic [PROD_W-1:0] p,
                                                  input logic neg);
        logic [QUOT_W-1:0] m;
        if (p[PROD_W-1:69] != '0 || (p[68] && p[67:8] != '0))
            m = TERM_CAP;
        else
            m = p[68:8];
        f_term = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign w_amag      = r_off[63] ? 64'(-r_off) : r_off;
    assign w_big_off   = (r_max_off != '0) && ({24'd0, r_max_off} < w_amag);
    assign w_big_first = (r_max_first_off != '0) && ({24'd0, r_max_first_off} < w_amag);
    assign w_dt        = r_t - r_first_t;
    assign w_dneg      = r_off < r_first_off;
    assign w_dmag      = w_dneg ? 64'(r_first_off - r_off) : 64'(r_off - r_first_off);
    assign w_lim       = $signed({17'd0, r_max_ppb, 16'd0});
    assign w_esum      = 63'(r_drift) + (r_neg ? -$signed({2'b0, w_quot})
                                               : $signed({2'b0, w_quot}));
    assign w_eclamp    = (w_esum < -w_lim) ? -w_lim : (w_esum > w_lim) ? w_lim : w_esum;
    assign w_term      = f_term(w_prod, r_off[63]);
    assign w_dsum      = 63'(r_drift) + 63'(r_iterm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_phase         <= PH_FIRST;
            r_prop_gain     <= 32'd11744051;
            r_integ_gain    <= 32'd5033165;
            r_max_ppb       <= 30'd900000000;
            r_max_off       <= '0;
            r_max_first_off <= 40'd100;
            r_min_int       <= 40'd53280053;
            r_drift         <= '0;
            r_pending       <= 1'b1;
            r_ov            <= 1'b0;
            r_mul_ctl       <= '0;
            r_div_start     <= 1'b0;
        end else begin
            r_mul_ctl.start <= 1'b0;
            r_div_start     <= 1'b0;
            if (o_out.ready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[31:0];
                    REG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data[31:0];
                    REG_MAX_PPB:       r_max_ppb       <= i_cfg_data[29:0];
                    REG_MAX_OFFSET:    r_max_off       <= i_cfg_data;
                    REG_MAX_FIRST_OFF: r_max_first_off <= i_cfg_data;
                    REG_MIN_EST_INT:   r_min_int       <= i_cfg_data;
                    REG_INIT_DRIFT:    r_drift <= $signed({{1{i_cfg_data[30]}},
                                                           i_cfg_data[30:0], 16'd0});
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_off   <= i_in.offset_ns;
                        r_t     <= i_in.local_time_ns;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res_ppb <= '0;
                    r_res_st  <= ST_UNLOCKED;
                    r_state   <= S_OUT;
                    case (r_phase)
                        PH_FIRST: begin
                            r_first_off <= r_off;
                            r_first_t   <= r_t;
                            r_phase     <= PH_EST;
                        end
                        PH_EST: begin
                            if (r_first_t >= r_t) begin
                                r_phase <= PH_FIRST;
                            end else if (w_dt >= {24'd0, r_min_int}) begin
                                r_dt          <= w_dt;
                                r_neg         <= w_dneg;
                                r_ma          <= w_dmag;
                                r_mb          <= NS_Q16;
                                r_mul_ctl     <= '{start: 1'b1, nbits: 6'(MULB_W)};
                                r_state       <= S_EMUL;
                            end
                        end
                        default: begin
                            if (w_big_off) begin
                                r_phase <= PH_FIRST;
                            end else begin
                                r_ma      <= w_amag;
                                r_mb      <= {r_integ_gain, 15'd0};
                                r_mul_ctl <= '{start: 1'b1, nbits: 6'd32};
                                r_state   <= S_IMUL;
                            end
                        end
                    endcase
                end
                S_EMUL: begin
                    if (w_mul_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    if (w_div_done) begin
                        r_drift   <= 48'(w_eclamp);
                        r_res_ppb <= 47'(w_eclamp);
                        r_res_st  <= (!r_pending || w_big_first || w_big_off)
                                     ? ST_JUMP : ST_LOCKED;
                        r_pending <= 1'b0;
                        r_phase   <= PH_LOCKED;
                        r_state   <= S_OUT;
                    end
                end
                S_IMUL: begin
                    if (w_mul_done) begin
                        r_iterm   <= w_term;
                        r_mb      <= {r_prop_gain, 15'd0};
                        r_mul_ctl <= '{start: 1'b1, nbits: 6'd32};
                        r_state   <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (w_mul_done) begin
                        r_sum   <= 63'(w_term) + 63'(r_drift) + 63'(r_iterm);
                        r_state <= S_PSUM;
                    end
                end
                S_PSUM: begin
                    r_res_st <= ST_LOCKED;
                    r_state  <= S_OUT;
                    if (r_sum < -w_lim) begin
                        r_res_ppb <= 47'(-w_lim);
                    end else if (r_sum > w_lim) begin
                        r_res_ppb <= 47'(w_lim);
                    end else begin
                        r_res_ppb <= 47'(r_sum);
                        // integrate only while the output is not saturated
                        if (w_dsum > 63'sh7FFF_FFFF_FFFF)
                            r_drift <= 48'sh7FFF_FFFF_FFFF;
                        else if (w_dsum < -63'sh7FFF_FFFF_FFFF)
                            r_drift <= -48'sh7FFF_FFFF_FFFF;
                        else
                            r_drift <= 48'(w_dsum);
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_corr  <= r_res_ppb;
                        r_st    <= r_res_st;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_ov;
    assign o_out.correction_ppb_q16 = r_corr;
    assign o_out.servo_status       = r_st;

`include "assert_macros.svh"
    `PICS_ASSERT(a_mul_done_owned, i_clk, i_rst_n, w_mul_done |-> (r_state == S_EMUL || r_state == S_IMUL || r_state == S_PMUL), "multiplier done outside a multiply state")
    `PICS_ASSERT(a_div_done_owned, i_clk, i_rst_n, w_div_done |-> (r_state == S_EDIV), "divider done outside the estimate state")
    `PICS_ASSERT(a_drift_range, i_clk, i_rst_n, !(r_drift[47] && r_drift[46:0] == '0), "drift left its range")
    `PICS_ASSERT(a_corr_limit, i_clk, i_rst_n, (o_out.valid && !r_corr[46]) |-> ({1'b0, r_corr} <= {2'b0, r_max_ppb, 16'd0}), "correction above limit")
endmodule
